// ===== rtl/sensor_temperature_compensation_top_macros.svh =====
// ----------------------------------------------------------------------------
// temperature compensation assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef SENSOR_TEMPERATURE_COMPENSATION_TOP_MACROS_SVH
`define SENSOR_TEMPERATURE_COMPENSATION_TOP_MACROS_SVH

// clocked assertion, switched off while reset is low
`define STC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// clocked assertion that also holds through reset
`define STC_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/stc_pkg.sv =====
// ----------------------------------------------------------------------------
// stc_pkg
// widths, register indexes, reset values and shared types
// ----------------------------------------------------------------------------
package stc_pkg;

    localparam int RAW_W       = 16;
    localparam int CAL_W       = 16;
    localparam int DIFF_W      = 17;
    localparam int PROD_W      = 34;
    localparam int X1_SHIFT    = 15;
    localparam int X1_W        = PROD_W - X1_SHIFT;
    localparam int MC_SHIFT    = 11;
    localparam int NUM_W       = CAL_W + MC_SHIFT;
    localparam int DEN_W       = X1_W - 1;
    localparam int B5_W        = 28;
    localparam int SUM_W       = B5_W + 1;
    localparam int T_SHIFT     = 4;
    localparam int TEMP_W      = 24;
    localparam int CFG_IDX_W   = 2;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 56;

    localparam logic [CFG_IDX_W-1:0] CFG_AC5 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AC6 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MC  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MD  = 2'd3;

    localparam logic [CAL_W-1:0] AC5_RST = 16'd32757;
    localparam logic [CAL_W-1:0] AC6_RST = 16'd23153;
    localparam logic [CAL_W-1:0] MC_RST  = 16'hDDF9;
    localparam logic [CAL_W-1:0] MD_RST  = 16'd2868;

    // (b5 + 8) / 16 toward zero: add 8, or 8 + 15 when the sum goes negative
    localparam logic signed [B5_W-1:0] B5_NEG_LIM = -28'sd8;
    localparam logic [SUM_W-1:0]       RND_POS    = 29'd8;
    localparam logic [SUM_W-1:0]       RND_NEG    = 29'd23;

    // side data carried alongside the divider
    typedef struct packed {
        logic [X1_W-1:0] x1;
        logic            neg;
        logic            dz;
    } t_div_side;

endpackage

// ===== rtl/stc_div.sv =====
// ----------------------------------------------------------------------------
// stc_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module stc_div import stc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    input  t_div_side        i_side,
    output logic             o_valid,
    output logic [NUM_W-1:0] o_quot,
    output t_div_side        o_side
);

    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [NUM_W-1:0] dvd;
        logic [DEN_W-1:0] den;
        t_div_side        side;
    } t_div_stage;

    logic [NUM_W-1:0] r_vld;
    t_div_stage       r_stg [NUM_W];
    t_div_stage       n_stg [NUM_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NUM_W-2:0], i_valid};
        end
    end

    for (genvar k = 0; k < NUM_W; k++) begin : g_step
        t_div_stage       w_prev;
        logic [DEN_W:0]   w_part;
        logic [DEN_W+1:0] w_diff;
        logic             w_ge;

        if (k == 0) begin : g_first
            assign w_prev.rem  = '0;
            assign w_prev.dvd  = i_num;
            assign w_prev.den  = i_den;
            assign w_prev.side = i_side;
        end else begin : g_next
            assign w_prev = r_stg[k-1];
        end

        // bring down the next dividend bit and try the subtract
        assign w_part = {w_prev.rem, w_prev.dvd[NUM_W-1]};
        assign w_diff = {1'b0, w_part} - {2'b00, w_prev.den};
        assign w_ge   = ~w_diff[DEN_W+1];

        assign n_stg[k].rem  = w_ge ? w_diff[DEN_W-1:0] : w_part[DEN_W-1:0];
        assign n_stg[k].dvd  = {w_prev.dvd[NUM_W-2:0], w_ge};
        assign n_stg[k].den  = w_prev.den;
        assign n_stg[k].side = w_prev.side;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_stg[k] <= n_stg[k];
            end
        end
    end

    assign o_valid = r_vld[NUM_W-1];
    assign o_quot  = r_stg[NUM_W-1].dvd;
    assign o_side  = r_stg[NUM_W-1].side;

endmodule

// ===== rtl/sensor_temperature_compensation_top.sv =====
// ----------------------------------------------------------------------------
// sensor temperature compensation
// an accepted input passes stages a to e, the divider stages, then f, g and h
// throughput: one transaction per cycle while the output is not stalled, set by the 27-stage divider pipeline
// a stall on the output freezes every stage at once, nothing is dropped
// reset (sync, active low) clears all valid bits and loads typical calibration
// ----------------------------------------------------------------------------
module sensor_temperature_compensation_top import stc_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // calibration write port
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [CAL_W-1:0]       i_cfg_wdata,
    // input stream
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,   // [15:0] raw_temp
    // output stream
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,   // [23:0] temp_tenths, [51:24] b5_term
    output logic                   o_m_axis_tuser    // [0] div_zero
);

    // ------------------------------------------------------------------
    // calibration registers, written by the user only while the pipe is empty (not enforced by the block)
    // ------------------------------------------------------------------
    logic [CAL_W-1:0] r_cal_ac5;
    logic [CAL_W-1:0] r_cal_ac6;
    logic [CAL_W-1:0] r_cal_mc;
    logic [CAL_W-1:0] r_cal_md;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_ac5 <= AC5_RST;
            r_cal_ac6 <= AC6_RST;
            r_cal_mc  <= MC_RST;
            r_cal_md  <= MD_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                CFG_AC5: r_cal_ac5 <= i_cfg_wdata;
                CFG_AC6: r_cal_ac6 <= i_cfg_wdata;
                CFG_MC:  r_cal_mc  <= i_cfg_wdata;
                CFG_MD:  r_cal_md  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // global advance: the whole pipe moves unless the output is stuck
    // ------------------------------------------------------------------
    logic w_en;
    logic r_h_vld;

    assign w_en            = ~r_h_vld | i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    // ------------------------------------------------------------------
    // stage a: offset-corrected reading ut - ac6
    // ------------------------------------------------------------------
    logic                     r_a_vld;
    logic signed [DIFF_W-1:0] r_a_diff;
    logic signed [DIFF_W-1:0] n_a_diff;

    assign n_a_diff = $signed({1'b0, i_s_axis_tdata[RAW_W-1:0]}) - $signed({1'b0, r_cal_ac6});

    // ------------------------------------------------------------------
    // stage b: gain product, 17 x 17 signed
    // ------------------------------------------------------------------
    logic                     r_b_vld;
    logic signed [PROD_W-1:0] r_b_prod;
    logic signed [PROD_W-1:0] n_b_prod;
    logic signed [DIFF_W-1:0] w_ac5_s;

    assign w_ac5_s  = $signed({1'b0, r_cal_ac5});
    assign n_b_prod = r_a_diff * w_ac5_s;

    // ------------------------------------------------------------------
    // stage c: x1 = prod / 2^15 toward zero (bias negative values first)
    // ------------------------------------------------------------------
    logic              r_c_vld;
    logic [X1_W-1:0]   r_c_x1;
    logic [PROD_W-1:0] w_c_bias;
    logic [PROD_W-1:0] w_c_adj;

    assign w_c_bias = {{(PROD_W-X1_SHIFT){1'b0}}, {X1_SHIFT{r_b_prod[PROD_W-1]}}};
    assign w_c_adj  = r_b_prod + w_c_bias;

    // ------------------------------------------------------------------
    // stage d: divisor x1 + md, the input to the stage e zero check
    // ------------------------------------------------------------------
    logic            r_d_vld;
    logic [X1_W-1:0] r_d_x1;
    logic [X1_W-1:0] r_d_den;
    logic [X1_W-1:0] n_d_den;

    assign n_d_den = r_c_x1 + {{(X1_W-CAL_W){r_cal_md[CAL_W-1]}}, r_cal_md};

    // ------------------------------------------------------------------
    // stage e: magnitudes, quotient sign and zero check for the unsigned divider
    // ------------------------------------------------------------------
    logic             r_e_vld;
    logic [NUM_W-1:0] r_e_num;
    logic [DEN_W-1:0] r_e_den;
    t_div_side        r_e_side;
    logic [X1_W-1:0]  w_e_den_abs;
    logic [CAL_W-1:0] w_e_mc_abs;

    assign w_e_den_abs = r_d_den[X1_W-1] ? (~r_d_den + 1'b1) : r_d_den;
    // most negative mc maps onto its own bit pattern, which is the right magnitude
    assign w_e_mc_abs  = r_cal_mc[CAL_W-1] ? (~r_cal_mc + 1'b1) : r_cal_mc;

    // ------------------------------------------------------------------
    // divider: |mc * 2^11| / |x1 + md|
    // ------------------------------------------------------------------
    logic             w_q_vld;
    logic [NUM_W-1:0] w_q_quot;
    t_div_side        w_q_side;

    stc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_e_vld),
        .i_num   (r_e_num),
        .i_den   (r_e_den),
        .i_side  (r_e_side),
        .o_valid (w_q_vld),
        .o_quot  (w_q_quot),
        .o_side  (w_q_side)
    );

    // ------------------------------------------------------------------
    // stage f: apply the quotient sign, x2
    // ------------------------------------------------------------------
    logic            r_f_vld;
    logic [B5_W-1:0] r_f_x2;
    logic [X1_W-1:0] r_f_x1;
    logic            r_f_dz;
    logic [B5_W-1:0] w_f_mag;

    assign w_f_mag = {{(B5_W-NUM_W){1'b0}}, w_q_quot};

    // ------------------------------------------------------------------
    // stage g: b5 = x1 + x2
    // ------------------------------------------------------------------
    logic                   r_g_vld;
    logic signed [B5_W-1:0] r_g_b5;
    logic                   r_g_dz;
    logic [B5_W-1:0]        n_g_b5;

    assign n_g_b5 = {{(B5_W-X1_W){r_f_x1[X1_W-1]}}, r_f_x1} + r_f_x2;

    // ------------------------------------------------------------------
    // stage h: t = (b5 + 8) / 16 toward zero, output register
    // ------------------------------------------------------------------
    logic [TEMP_W-1:0] r_h_temp;
    logic [B5_W-1:0]   r_h_b5;
    logic              r_h_dz;
    logic [SUM_W-1:0]  w_h_sum;

    assign w_h_sum = {r_g_b5[B5_W-1], r_g_b5}
                   + ((r_g_b5 < B5_NEG_LIM) ? RND_NEG : RND_POS);

    // ------------------------------------------------------------------
    // valid chain
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
            r_g_vld <= 1'b0;
            r_h_vld <= 1'b0;
        end else if (w_en) begin
            r_a_vld <= i_s_axis_tvalid;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
            r_e_vld <= r_d_vld;
            r_f_vld <= w_q_vld;
            r_g_vld <= r_f_vld;
            r_h_vld <= r_g_vld;
        end
    end

    // ------------------------------------------------------------------
    // payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_diff <= n_a_diff;
            r_b_prod <= n_b_prod;
            r_c_x1   <= w_c_adj[PROD_W-1:X1_SHIFT];
            r_d_x1   <= r_c_x1;
            r_d_den  <= n_d_den;

            r_e_num       <= {w_e_mc_abs, {MC_SHIFT{1'b0}}};
            r_e_den       <= w_e_den_abs[DEN_W-1:0];
            r_e_side.x1   <= r_d_x1;
            r_e_side.neg  <= r_cal_mc[CAL_W-1] ^ r_d_den[X1_W-1];
            r_e_side.dz   <= (r_d_den == '0);

            r_f_x2 <= w_q_side.neg ? (~w_f_mag + 1'b1) : w_f_mag;
            r_f_x1 <= w_q_side.x1;
            r_f_dz <= w_q_side.dz;

            r_g_b5 <= $signed(n_g_b5);
            r_g_dz <= r_f_dz;

            // zero divisor forces both results to zero
            r_h_temp <= r_g_dz ? '0 : w_h_sum[TEMP_W+T_SHIFT-1:T_SHIFT];
            r_h_b5   <= r_g_dz ? '0 : r_g_b5;
            r_h_dz   <= r_g_dz;
        end
    end

    assign o_m_axis_tvalid = r_h_vld;
    assign o_m_axis_tdata  = {{(OUT_TDATA_W-B5_W-TEMP_W){1'b0}}, r_h_b5, r_h_temp};
    assign o_m_axis_tuser  = r_h_dz;

endmodule

// ===== rtl/stc_chk.sv =====
// ----------------------------------------------------------------------------
// stc_chk
// port-level checks for the temperature compensation block
// ----------------------------------------------------------------------------
`include "sensor_temperature_compensation_top_macros.svh"

module stc_chk import stc_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_cfg_wr_en,
    input logic [CFG_IDX_W-1:0]   i_cfg_addr,
    input logic [CAL_W-1:0]       i_cfg_wdata,
    input logic                   i_s_axis_tvalid,
    input logic                   o_s_axis_tready,
    input logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    input logic                   o_m_axis_tvalid,
    input logic                   i_m_axis_tready,
    input logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    input logic                   o_m_axis_tuser
);

    // a held result stays offered
    `STC_ASSERT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid, "output valid dropped under stall")

    // a held result keeps its payload
    `STC_ASSERT(a_out_stable, o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser), "output payload changed under stall")

    // zero divisor gives zero results
    `STC_ASSERT(a_dz_zero, o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tdata == '0, "div_zero result not cleared")

    // an empty output stage never blocks the input
    `STC_ASSERT(a_ready_free, !o_m_axis_tvalid |-> o_s_axis_tready, "input stalled with empty output")

    // reset empties the pipe
    `STC_ASSERT_RST(a_rst_empty, !i_rst_n |=> !o_m_axis_tvalid, "output valid after reset")

endmodule

bind sensor_temperature_compensation_top stc_chk u_stc_chk (.*);
